// ===== hdl/assc_pkg.sv =====
// Shared types and constants for the alarm siren sweep controller.
`timescale 1ns / 1ps

package assc_pkg;

  localparam int unsigned DurW  = 16;
  localparam int unsigned ToneW = 12;
  localparam int unsigned RefW  = 8;
  localparam int unsigned PhW   = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [PhW-1:0] PH_IDLE = 2'd0;
  localparam logic [PhW-1:0] PH_RISE = 2'd1;
  localparam logic [PhW-1:0] PH_FALL = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_ALARM_DURATION = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SWEEP_LIMIT    = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_STROBE_CUT     = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_REFRESH_RELOAD = 2'd3;

  localparam logic [DurW-1:0]  RST_ALARM_DURATION = 16'd5000;
  localparam logic [ToneW-1:0] RST_SWEEP_LIMIT    = 12'd2000;
  localparam logic [ToneW-1:0] RST_STROBE_CUT     = 12'd1000;
  localparam logic [RefW-1:0]  RST_REFRESH_RELOAD = 8'd5;

  typedef struct packed {
    logic [DurW-1:0]  alarm_duration;
    logic [ToneW-1:0] sweep_limit;
    logic [ToneW-1:0] strobe_cut;
    logic [RefW-1:0]  refresh_reload;
  } cfg_t;

  typedef struct packed {
    logic [PhW-1:0]   phase;
    logic [ToneW-1:0] sweep_position;
    logic [DurW-1:0]  alarm_countdown;
    logic [RefW-1:0]  refresh_countdown;
    logic             strobe_level;
  } state_t;

  typedef struct packed {
    logic             zone_one_light;
    logic             zone_two_light;
    logic             strobe_on;
    logic             siren_stop;
    logic             tone_update;
    logic [ToneW-1:0] tone_value;
    logic [PhW-1:0]   siren_phase;
  } res_t;

endpackage

// ===== hdl/assc_step.sv =====
// Next-state and result logic for one millisecond tick.
`timescale 1ns / 1ps

module assc_step (
  input  assc_pkg::cfg_t   cfg,
  input  assc_pkg::state_t st,
  input  logic             motion_zone_one,
  input  logic             motion_zone_two,
  input  logic             silence_pressed,
  input  logic             system_armed,
  output assc_pkg::state_t st_nxt,
  output assc_pkg::res_t   res
);

  logic stop;
  logic update;
  logic go_idle;

  always_comb begin
    st_nxt  = st;
    stop    = 1'b0;
    update  = 1'b0;
    go_idle = (st.alarm_countdown == '0) || silence_pressed;
    if (system_armed) begin
      priority if (st.phase == assc_pkg::PH_RISE) begin
        if (go_idle) begin
          st_nxt.phase = assc_pkg::PH_IDLE;
        end else begin
          st_nxt.alarm_countdown = st.alarm_countdown - 1'b1;
        end
        if (st.sweep_position > cfg.strobe_cut) begin
          st_nxt.strobe_level = 1'b0;
        end
        if (st.sweep_position < cfg.sweep_limit) begin
          st_nxt.sweep_position = st.sweep_position + 1'b1;
        end else begin
          st_nxt.phase = assc_pkg::PH_FALL;
        end
      end else if (st.phase == assc_pkg::PH_FALL) begin
        if (go_idle) begin
          st_nxt.phase = assc_pkg::PH_IDLE;
        end else begin
          st_nxt.alarm_countdown = st.alarm_countdown - 1'b1;
        end
        if (st.sweep_position != '0) begin
          st_nxt.sweep_position = st.sweep_position - 1'b1;
        end else begin
          st_nxt.phase = assc_pkg::PH_RISE;
        end
      end else begin
        stop                = 1'b1;
        st_nxt.phase        = assc_pkg::PH_IDLE;
        st_nxt.strobe_level = 1'b0;
        if (motion_zone_one || motion_zone_two) begin
          st_nxt.strobe_level    = 1'b1;
          st_nxt.phase           = assc_pkg::PH_RISE;
          st_nxt.sweep_position  = '0;
          st_nxt.alarm_countdown = cfg.alarm_duration;
        end
      end
      if (st_nxt.phase != assc_pkg::PH_IDLE) begin
        if (st.refresh_countdown != '0) begin
          st_nxt.refresh_countdown = st.refresh_countdown - 1'b1;
        end else begin
          st_nxt.refresh_countdown = cfg.refresh_reload;
          update                   = 1'b1;
        end
      end
    end
  end

  always_comb begin
    res.zone_one_light = motion_zone_one;
    res.zone_two_light = motion_zone_two;
    res.strobe_on      = st_nxt.strobe_level;
    res.siren_stop     = stop;
    res.tone_update    = update;
    res.tone_value     = st_nxt.sweep_position;
    res.siren_phase    = st_nxt.phase;
  end

endmodule

// ===== hdl/alarm_siren_sweep_controller.sv =====
// Top level of the alarm siren sweep controller: state, config, output buffer.
`timescale 1ns / 1ps

//  channel | handshake         | payload
//  in      | in_valid/in_stall | motion zones, silence, armed
//  out     | out_valid/out_stall | lights, strobe, stop, tone, phase
//  cfg     | cfg_we            | cfg_index, cfg_wdata
// One tick per cycle while in_stall is low; each result is registered on transfer.
// The combinational next-state update of the siren state sets the rate.
// A two-entry output buffer (register plus skid) takes a tick while a result waits.
// in_stall rises only when both entries are full. Reset is synchronous, rst_n low.

module alarm_siren_sweep_controller (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_motion_zone_one,
  input  logic                            in_motion_zone_two,
  input  logic                            in_silence_pressed,
  input  logic                            in_system_armed,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_zone_one_light,
  output logic                            out_zone_two_light,
  output logic                            out_strobe_on,
  output logic                            out_siren_stop,
  output logic                            out_tone_update,
  output logic [assc_pkg::ToneW-1:0]      out_tone_value,
  output logic [assc_pkg::PhW-1:0]        out_siren_phase,
  input  logic                            cfg_we,
  input  logic [assc_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [assc_pkg::CfgDataW-1:0]   cfg_wdata
);

  assc_pkg::cfg_t   cfg_r;
  assc_pkg::state_t st_r;
  assc_pkg::state_t st_nxt;
  assc_pkg::res_t   res;
  assc_pkg::res_t   out_r;
  assc_pkg::res_t   skid_r;
  logic             out_valid_r;
  logic             skid_valid_r;
  logic             in_xfer;
  logic             out_free;

  assign in_stall = skid_valid_r;
  assign in_xfer  = in_valid && !skid_valid_r;
  assign out_free = !out_valid_r || !out_stall;

  assc_step u_step (
    .cfg             (cfg_r),
    .st              (st_r),
    .motion_zone_one (in_motion_zone_one),
    .motion_zone_two (in_motion_zone_two),
    .silence_pressed (in_silence_pressed),
    .system_armed    (in_system_armed),
    .st_nxt          (st_nxt),
    .res             (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alarm_duration <= assc_pkg::RST_ALARM_DURATION;
      cfg_r.sweep_limit    <= assc_pkg::RST_SWEEP_LIMIT;
      cfg_r.strobe_cut     <= assc_pkg::RST_STROBE_CUT;
      cfg_r.refresh_reload <= assc_pkg::RST_REFRESH_RELOAD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        assc_pkg::REG_ALARM_DURATION: cfg_r.alarm_duration <= cfg_wdata;
        assc_pkg::REG_SWEEP_LIMIT:    cfg_r.sweep_limit <= cfg_wdata[assc_pkg::ToneW-1:0];
        assc_pkg::REG_STROBE_CUT:     cfg_r.strobe_cut <= cfg_wdata[assc_pkg::ToneW-1:0];
        assc_pkg::REG_REFRESH_RELOAD: cfg_r.refresh_reload <= cfg_wdata[assc_pkg::RefW-1:0];
        default: ;
      endcase
    end
  end

  // advance siren state on each tick transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase             <= assc_pkg::PH_IDLE;
      st_r.sweep_position    <= '0;
      st_r.alarm_countdown   <= '0;
      st_r.refresh_countdown <= assc_pkg::RST_REFRESH_RELOAD;
      st_r.strobe_level      <= 1'b0;
    end else if (in_xfer) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r  <= skid_valid_r || in_xfer;
      skid_valid_r <= 1'b0;
    end else if (in_xfer) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (in_xfer) begin
        out_r <= res;
      end
    end else if (in_xfer) begin
      skid_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_zone_one_light = out_r.zone_one_light;
  assign out_zone_two_light = out_r.zone_two_light;
  assign out_strobe_on      = out_r.strobe_on;
  assign out_siren_stop     = out_r.siren_stop;
  assign out_tone_update    = out_r.tone_update;
  assign out_tone_value     = out_r.tone_value;
  assign out_siren_phase    = out_r.siren_phase;

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without an output entry");

  a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase == assc_pkg::PH_IDLE || st_r.phase == assc_pkg::PH_RISE ||
    st_r.phase == assc_pkg::PH_FALL)
    else $error("siren phase register holds an unused code");

  a_update_sounding: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.tone_update |-> out_r.siren_phase != assc_pkg::PH_IDLE)
    else $error("tone update while idle");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_xfer |=> $stable(st_r))
    else $error("siren state changed without a tick transfer");

endmodule

// ===== tb/tb_alarm_siren_sweep_controller.sv =====
// Self-checking testbench for the alarm siren sweep controller.
`timescale 1ns / 1ps

module tb_alarm_siren_sweep_controller;

  localparam int WatchdogLimit = 4000;
  localparam int unsigned DurW     = assc_pkg::DurW;
  localparam int unsigned ToneW    = assc_pkg::ToneW;
  localparam int unsigned RefW     = assc_pkg::RefW;
  localparam int unsigned PhW      = assc_pkg::PhW;
  localparam int unsigned CfgIdxW  = assc_pkg::CfgIdxW;
  localparam int unsigned CfgDataW = assc_pkg::CfgDataW;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_motion_zone_one = 1'b0;
  logic                in_motion_zone_two = 1'b0;
  logic                in_silence_pressed = 1'b0;
  logic                in_system_armed = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_zone_one_light;
  logic                out_zone_two_light;
  logic                out_strobe_on;
  logic                out_siren_stop;
  logic                out_tone_update;
  logic [ToneW-1:0]    out_tone_value;
  logic [PhW-1:0]      out_siren_phase;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  assc_pkg::state_t siren_st;
  assc_pkg::cfg_t   siren_cfg;
  assc_pkg::res_t   siren_results_q[$];

  int  err_count = 0;
  int  ticks_sent = 0;
  int  results_checked = 0;
  int  tone_refreshes = 0;
  int  stop_commands = 0;
  int  settings_used = 0;
  int  quiet_cycles = 0;
  int  stall_left = 0;
  bit  gap_mode = 1'b0;
  bit  stall_mode = 1'b0;
  bit  hold_req = 1'b0;

  always #6 clk = ~clk;

  alarm_siren_sweep_controller dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_motion_zone_one (in_motion_zone_one),
    .in_motion_zone_two (in_motion_zone_two),
    .in_silence_pressed (in_silence_pressed),
    .in_system_armed    (in_system_armed),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_zone_one_light (out_zone_one_light),
    .out_zone_two_light (out_zone_two_light),
    .out_strobe_on      (out_strobe_on),
    .out_siren_stop     (out_siren_stop),
    .out_tone_update    (out_tone_update),
    .out_tone_value     (out_tone_value),
    .out_siren_phase    (out_siren_phase),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  task automatic run_down_alarm(input logic silence);
    if (siren_st.alarm_countdown == '0 || silence) begin
      siren_st.phase = assc_pkg::PH_IDLE;
    end else begin
      siren_st.alarm_countdown = siren_st.alarm_countdown - 1'b1;
    end
  endtask

  task automatic predict_siren_tick(input logic m1, m2, silence, armed);
    assc_pkg::res_t r;
    r = '0;
    if (armed) begin
      case (siren_st.phase)
        assc_pkg::PH_RISE: begin
          run_down_alarm(silence);
          if (siren_st.sweep_position > siren_cfg.strobe_cut) begin
            siren_st.strobe_level = 1'b0;
          end
          if (siren_st.sweep_position < siren_cfg.sweep_limit) begin
            siren_st.sweep_position = siren_st.sweep_position + 1'b1;
          end else begin
            siren_st.phase = assc_pkg::PH_FALL;
          end
        end
        assc_pkg::PH_FALL: begin
          run_down_alarm(silence);
          if (siren_st.sweep_position > '0) begin
            siren_st.sweep_position = siren_st.sweep_position - 1'b1;
          end else begin
            siren_st.phase = assc_pkg::PH_RISE;
          end
        end
        default: begin
          siren_st.phase = assc_pkg::PH_IDLE;
          r.siren_stop = 1'b1;
          siren_st.strobe_level = 1'b0;
          if (m1 || m2) begin
            siren_st.strobe_level = 1'b1;
            siren_st.phase = assc_pkg::PH_RISE;
            siren_st.sweep_position = '0;
            siren_st.alarm_countdown = siren_cfg.alarm_duration;
          end
        end
      endcase
      if (siren_st.phase != assc_pkg::PH_IDLE) begin
        if (siren_st.refresh_countdown > '0) begin
          siren_st.refresh_countdown = siren_st.refresh_countdown - 1'b1;
        end else begin
          siren_st.refresh_countdown = siren_cfg.refresh_reload;
          r.tone_update = 1'b1;
        end
      end
    end
    r.zone_one_light = m1;
    r.zone_two_light = m2;
    r.strobe_on = siren_st.strobe_level;
    r.tone_value = siren_st.sweep_position;
    r.siren_phase = siren_st.phase;
    tone_refreshes += r.tone_update;
    stop_commands += r.siren_stop;
    siren_results_q.push_back(r);
  endtask

  task automatic send_tick(input logic m1, m2, silence, armed);
    int gap;
    gap = (gap_mode && $urandom_range(0, 2) == 0) ? pick_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_motion_zone_one <= m1;
    in_motion_zone_two <= m2;
    in_silence_pressed <= silence;
    in_system_armed <= armed;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_siren_tick(m1, m2, silence, armed);
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic send_random_tick();
    logic m1, m2, silence, armed;
    if ($urandom_range(0, 99) < 85) begin
      armed = ($urandom_range(0, 99) < 92);
      m1 = ($urandom_range(0, 99) < 12);
      m2 = ($urandom_range(0, 99) < 12);
      silence = ($urandom_range(0, 99) < 4);
    end else begin
      {m1, m2, silence, armed} = 4'($urandom);
    end
    send_tick(m1, m2, silence, armed);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (siren_results_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic program_regs(input logic [DurW-1:0] duration, input logic [ToneW-1:0] limit,
                              input logic [ToneW-1:0] cut, input logic [RefW-1:0] reload);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= assc_pkg::REG_ALARM_DURATION;
    cfg_wdata <= duration;
    @(negedge clk);
    cfg_index <= assc_pkg::REG_SWEEP_LIMIT;
    cfg_wdata <= CfgDataW'(limit);
    @(negedge clk);
    cfg_index <= assc_pkg::REG_STROBE_CUT;
    cfg_wdata <= CfgDataW'(cut);
    @(negedge clk);
    cfg_index <= assc_pkg::REG_REFRESH_RELOAD;
    cfg_wdata <= CfgDataW'(reload);
    @(negedge clk);
    cfg_we <= 1'b0;
    siren_cfg.alarm_duration = duration;
    siren_cfg.sweep_limit = limit;
    siren_cfg.strobe_cut = cut;
    siren_cfg.refresh_reload = reload;
    settings_used++;
  endtask

  task automatic run_random_ticks(input int count);
    gap_mode = ($urandom_range(0, 3) != 0);
    stall_mode = ($urandom_range(0, 3) != 0);
    repeat (count) send_random_tick();
  endtask

  task automatic test_idle_and_lights();
    gap_mode = 1'b1;
    stall_mode = 1'b1;
    send_tick(0, 0, 0, 0);
    send_tick(0, 0, 0, 1);
    send_tick(1, 0, 0, 0);
    send_tick(1, 0, 0, 1);
    send_tick(0, 1, 0, 1);
    send_tick(1, 1, 0, 1);
    send_tick(0, 0, 0, 0);
    send_tick(0, 0, 1, 0);
    send_tick(0, 0, 1, 1);
    send_tick(0, 1, 0, 1);
    send_tick(1, 1, 1, 1);
  endtask

  task automatic test_sweep_turns();
    program_regs(16'd6, 12'd2, 12'd0, 8'd0);
    send_tick(1, 0, 0, 1);
    send_tick(0, 0, 0, 1);
    send_tick(0, 0, 0, 1);
    send_tick(0, 0, 1, 1);
    repeat (5) send_tick(0, 0, 0, 1);
  endtask

  task automatic test_zero_extremes();
    program_regs(16'd0, 12'd0, 12'hFFF, 8'hFF);
    send_tick(0, 1, 0, 1);
    repeat (3) send_tick(0, 0, 0, 1);
  endtask

  task automatic test_random_settings();
    logic [DurW-1:0]  duration;
    logic [ToneW-1:0] limit, cut;
    logic [RefW-1:0]  reload;
    program_regs(16'd0, 12'd1, 12'd0, 8'd0);
    run_random_ticks(140);
    program_regs(16'hFFFF, 12'hFFF, 12'hFFF, 8'hFF);
    run_random_ticks(140);
    program_regs(16'd40, 12'd0, 12'hFFF, 8'hFF);
    run_random_ticks(140);
    repeat (10) begin
      duration = ($urandom_range(0, 99) < 20) ? DurW'($urandom) : DurW'($urandom_range(0, 60));
      limit = ($urandom_range(0, 99) < 80) ? ToneW'($urandom_range(0, 12)) : ToneW'($urandom);
      cut = ($urandom_range(0, 99) < 80) ? ToneW'($urandom_range(0, 14)) : ToneW'($urandom);
      reload = ($urandom_range(0, 99) < 70) ? RefW'($urandom_range(0, 3)) : RefW'($urandom);
      program_regs(duration, limit, cut, reload);
      run_random_ticks(140);
    end
  endtask

  task automatic test_receiver_holdoff();
    program_regs(16'd30, 12'd5, 12'd3, 8'd1);
    gap_mode = 1'b0;
    stall_mode = 1'b0;
    hold_req = 1'b1;
    repeat (60) send_random_tick();
    run_random_ticks(40);
  endtask

  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      stall_left = 80;
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (stall_mode && $urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      stall_left = pick_len() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0d got %0d", $time, name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    assc_pkg::res_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (siren_results_q.size() == 0) begin
        $display("%0t ns: result transfer with nothing expected", $time);
        err_count++;
      end else begin
        want = siren_results_q.pop_front();
        compare_field("zone_one_light", 16'(want.zone_one_light), 16'(out_zone_one_light));
        compare_field("zone_two_light", 16'(want.zone_two_light), 16'(out_zone_two_light));
        compare_field("strobe_on", 16'(want.strobe_on), 16'(out_strobe_on));
        compare_field("siren_stop", 16'(want.siren_stop), 16'(out_siren_stop));
        compare_field("tone_update", 16'(want.tone_update), 16'(out_tone_update));
        compare_field("tone_value", 16'(want.tone_value), 16'(out_tone_value));
        compare_field("siren_phase", 16'(want.siren_phase), 16'(out_siren_phase));
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t ns: no transfer for %0d cycles", $time, WatchdogLimit);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    siren_cfg.alarm_duration = assc_pkg::RST_ALARM_DURATION;
    siren_cfg.sweep_limit = assc_pkg::RST_SWEEP_LIMIT;
    siren_cfg.strobe_cut = assc_pkg::RST_STROBE_CUT;
    siren_cfg.refresh_reload = assc_pkg::RST_REFRESH_RELOAD;
    siren_st.phase = assc_pkg::PH_IDLE;
    siren_st.sweep_position = '0;
    siren_st.alarm_countdown = '0;
    siren_st.refresh_countdown = assc_pkg::RST_REFRESH_RELOAD;
    siren_st.strobe_level = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_idle_and_lights();
    test_sweep_turns();
    test_zero_extremes();
    test_random_settings();
    test_receiver_holdoff();
    wait_drained();
    $display("Covered %0d ticks over %0d register settings plus reset values,", ticks_sent,
             settings_used);
    $display("with %0d results checked, %0d tone refreshes and %0d siren stops.",
             results_checked, tone_refreshes, stop_commands);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
